// File: sv/lcg_pkg.sv
// Shared types, constants and modular add for the jump-ahead LCG.
package lcg_pkg;

    localparam int VALUE_WIDTH     = 31;
    localparam int POSITION_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CNT_WIDTH       = $clog2(VALUE_WIDTH + 1);

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_INCREMENT  = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SEED       = 2'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS    = 2'd3;

    localparam logic [VALUE_WIDTH-1:0] RST_MULTIPLIER = VALUE_WIDTH'(55);
    localparam logic [VALUE_WIDTH-1:0] RST_INCREMENT  = VALUE_WIDTH'(66);
    localparam logic [VALUE_WIDTH-1:0] RST_SEED       = VALUE_WIDTH'(777);
    localparam logic [VALUE_WIDTH-1:0] RST_MODULUS    = VALUE_WIDTH'(1457999);

    // Request codes
    localparam logic REQ_NEXT = 1'b0;
    localparam logic REQ_SEEK = 1'b1;

    // Operations of the shared modular unit
    localparam logic OP_MUL    = 1'b0;
    localparam logic OP_REDUCE = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [POSITION_WIDTH-1:0] target_position;
    } lcg_req_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]    rand_value;
        logic [POSITION_WIDTH-1:0] value_position;
    } lcg_rsp_t;

    typedef struct packed {
        logic start;
        logic op;
    } mm_cmd_t;

    // (a + b) mod m for a, b < m
    function automatic logic [VALUE_WIDTH-1:0] add_mod(input logic [VALUE_WIDTH-1:0] a,
                                                       input logic [VALUE_WIDTH-1:0] b,
                                                       input logic [VALUE_WIDTH-1:0] m);
        logic [VALUE_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

endpackage

// File: sv/lcg_modarith.sv
// Bit-serial modular multiply and modular reduce unit, one bit per cycle.
module lcg_modarith (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lcg_pkg::mm_cmd_t                 cmd,
    input  logic [lcg_pkg::VALUE_WIDTH-1:0]  x_in,
    input  logic [lcg_pkg::VALUE_WIDTH-1:0]  y_in,
    input  logic [lcg_pkg::VALUE_WIDTH-1:0]  m_in,
    output logic                             busy,
    output logic [lcg_pkg::VALUE_WIDTH-1:0]  result
);
    import lcg_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   op_reg, op_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] dbl_reg, dbl_next;
    logic [VALUE_WIDTH-1:0] y_reg, y_next;
    logic [CNT_WIDTH-1:0]   cnt_reg, cnt_next;
    logic [VALUE_WIDTH:0]   lane_in;
    logic [VALUE_WIDTH:0]   lane_out;

    always_comb begin
        // doubling lane: 2*d mod m, or shift in the next dividend bit when reducing
        lane_in  = {dbl_reg, (op_reg == OP_REDUCE) ? y_reg[VALUE_WIDTH-1] : 1'b0};
        lane_out = (lane_in >= {1'b0, m_in}) ? lane_in - {1'b0, m_in} : lane_in;

        busy_next = busy_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        dbl_next  = dbl_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;

        if (cmd.start) begin
            op_next  = cmd.op;
            cnt_next = CNT_WIDTH'(VALUE_WIDTH);
            y_next   = y_in;
            acc_next = '0;
            if (cmd.op == OP_MUL) begin
                dbl_next  = x_in;
                busy_next = (y_in != '0);
            end else begin
                dbl_next  = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            dbl_next = lane_out[VALUE_WIDTH-1:0];
            cnt_next = cnt_reg - CNT_WIDTH'(1);
            if (op_reg == OP_MUL) begin
                if (y_reg[0]) begin
                    acc_next = add_mod(acc_reg, dbl_reg, m_in);
                end
                y_next    = y_reg >> 1;
                busy_next = (y_reg[VALUE_WIDTH-1:1] != '0);
            end else begin
                y_next    = y_reg << 1;
                busy_next = (cnt_reg != CNT_WIDTH'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            op_reg   <= OP_MUL;
        end else begin
            busy_reg <= busy_next;
            op_reg   <= op_next;
        end
        acc_reg <= acc_next;
        dbl_reg <= dbl_next;
        y_reg   <= y_next;
        cnt_reg <= cnt_next;
    end

    assign busy   = busy_reg;
    assign result = (op_reg == OP_REDUCE) ? dbl_reg : acc_reg;

endmodule

// File: sv/lcg_jump_ahead_generator.sv
// Top level: LCG with jump-ahead, sequencer around one bit-serial modular unit.
// A next request reduces each operand that is at or above the modulus on the shared unit
//   and, once started, runs one multiply; a seek runs up to four multiplies per bit of the
//   target index.
// One request at a time; throughput is set by the single shared multiply/reduce unit.
// Reset (aresetn low, synchronous) loads register defaults and clears value, position, start.
module lcg_jump_ahead_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  lcg_pkg::lcg_req_t                   s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lcg_pkg::lcg_rsp_t                   m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lcg_pkg::VALUE_WIDTH-1:0]     cfg_data
);
    import lcg_pkg::*;

    // Sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_RED      = 4'd1;   // check or start reduction of one operand
    localparam logic [3:0] ST_RED_WB   = 4'd2;   // take reduced operand
    localparam logic [3:0] ST_DISPATCH = 4'd3;
    localparam logic [3:0] ST_WAIT     = 4'd4;   // wait on unit, then go to ret_reg
    localparam logic [3:0] ST_JBIT     = 4'd5;
    localparam logic [3:0] ST_JB_RA    = 4'd6;
    localparam logic [3:0] ST_JB_RB    = 4'd7;
    localparam logic [3:0] ST_JSQ      = 4'd8;
    localparam logic [3:0] ST_SQ_B     = 4'd9;
    localparam logic [3:0] ST_SQ_A     = 4'd10;
    localparam logic [3:0] ST_FIN_ADD  = 4'd11;
    localparam logic [3:0] ST_DELIVER  = 4'd12;

    // Operand slots for the reduction pass
    localparam logic [1:0] RED_A = 2'd0;
    localparam logic [1:0] RED_B = 2'd1;
    localparam logic [1:0] RED_X = 2'd2;

    // Configuration registers
    logic [VALUE_WIDTH-1:0] mult_reg, incr_reg, seed_reg, modulus_reg;

    // Sequencer and working registers
    logic [3:0]                state_reg, state_next;
    logic [3:0]                ret_reg, ret_next;
    logic [1:0]                red_idx_reg, red_idx_next;
    lcg_req_t                  req_reg, req_next;
    logic [POSITION_WIDTH-1:0] k_reg, k_next;
    logic [VALUE_WIDTH-1:0]    ba_reg, ba_next;   // base map multiplier
    logic [VALUE_WIDTH-1:0]    bb_reg, bb_next;   // base map increment
    logic [VALUE_WIDTH-1:0]    ra_reg, ra_next;   // accumulated map multiplier
    logic [VALUE_WIDTH-1:0]    rb_reg, rb_next;   // accumulated map increment
    logic [VALUE_WIDTH-1:0]    xv_reg, xv_next;   // reduced start value

    // Generator state
    logic [VALUE_WIDTH-1:0]    cur_val_reg, cur_val_next;
    logic [POSITION_WIDTH-1:0] cur_pos_reg, cur_pos_next;
    logic                      started_reg, started_next;

    // Output word
    logic                      m_valid_reg, m_valid_next;
    lcg_rsp_t                  m_data_reg, m_data_next;

    // Shared unit
    mm_cmd_t                   mm_cmd;
    logic [VALUE_WIDTH-1:0]    mm_x, mm_y, mm_result;
    logic                      mm_busy;

    logic [VALUE_WIDTH-1:0]    m_eff;
    logic [VALUE_WIDTH-1:0]    red_val;
    logic [VALUE_WIDTH-1:0]    red_res;
    logic                      red_direct;
    logic                      use_seed;

    // A modulus of 0 or 1 behaves as 1
    assign m_eff = (modulus_reg < VALUE_WIDTH'(2)) ? VALUE_WIDTH'(1) : modulus_reg;

    // Seek and the first next start from the seed, otherwise from the held value
    assign use_seed = (req_reg.req_type == REQ_SEEK) || !started_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    lcg_modarith u_modarith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mm_cmd),
        .x_in    (mm_x),
        .y_in    (mm_y),
        .m_in    (m_eff),
        .busy    (mm_busy),
        .result  (mm_result)
    );

    // Configuration writes; by contract only while idle, which the block does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg    <= RST_MULTIPLIER;
            incr_reg    <= RST_INCREMENT;
            seed_reg    <= RST_SEED;
            modulus_reg <= RST_MODULUS;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MULTIPLIER: mult_reg    <= cfg_data;
                REG_INCREMENT:  incr_reg    <= cfg_data;
                REG_SEED:       seed_reg    <= cfg_data;
                REG_MODULUS:    modulus_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Operand under reduction; skip the unit when it is already below the modulus
    always_comb begin
        unique case (red_idx_reg)
            RED_A:   red_val = mult_reg;
            RED_B:   red_val = incr_reg;
            default: red_val = use_seed ? seed_reg : cur_val_reg;
        endcase
        red_direct = (red_val < m_eff);
        red_res    = (state_reg == ST_RED_WB) ? mm_result : red_val;
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        red_idx_next = red_idx_reg;
        req_next     = req_reg;
        k_next       = k_reg;
        ba_next      = ba_reg;
        bb_next      = bb_reg;
        ra_next      = ra_reg;
        rb_next      = rb_reg;
        xv_next      = xv_reg;
        cur_val_next = cur_val_reg;
        cur_pos_next = cur_pos_reg;
        started_next = started_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mm_cmd       = '0;
        mm_x         = ba_reg;
        mm_y         = xv_reg;

        // Drop the output word once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next     = s_data;
                    k_next       = s_data.target_position;
                    red_idx_next = RED_A;
                    state_next   = ST_RED;
                end
            end

            ST_RED, ST_RED_WB: begin
                if (state_reg == ST_RED && !red_direct) begin
                    // Long reduction on the shared unit
                    mm_cmd.start = 1'b1;
                    mm_cmd.op    = OP_REDUCE;
                    mm_y         = red_val;
                    ret_next     = ST_RED_WB;
                    state_next   = ST_WAIT;
                end else begin
                    unique case (red_idx_reg)
                        RED_A:   ba_next = red_res;
                        RED_B:   bb_next = red_res;
                        default: xv_next = red_res;
                    endcase
                    if (red_idx_reg == RED_X) begin
                        state_next = ST_DISPATCH;
                    end else begin
                        red_idx_next = red_idx_reg + 2'd1;
                        state_next   = ST_RED;
                    end
                end
            end

            ST_DISPATCH: begin
                priority if (req_reg.req_type == REQ_SEEK) begin
                    // Identity map: ra = 1 mod m, rb = 0
                    ra_next    = (m_eff == VALUE_WIDTH'(1)) ? '0 : VALUE_WIDTH'(1);
                    rb_next    = '0;
                    state_next = ST_JBIT;
                end else if (!started_reg) begin
                    cur_val_next = xv_reg;
                    cur_pos_next = '0;
                    started_next = 1'b1;
                    state_next   = ST_DELIVER;
                end else begin
                    // One step: a*x, then add b in the final add
                    mm_cmd.start = 1'b1;
                    mm_cmd.op    = OP_MUL;
                    mm_x         = ba_reg;
                    mm_y         = xv_reg;
                    rb_next      = bb_reg;
                    ret_next     = ST_FIN_ADD;
                    state_next   = ST_WAIT;
                end
            end

            ST_WAIT: begin
                if (!mm_busy) begin
                    state_next = ret_reg;
                end
            end

            ST_JBIT: begin
                mm_cmd.start = 1'b1;
                mm_cmd.op    = OP_MUL;
                priority if (k_reg == '0) begin
                    mm_x     = ra_reg;
                    mm_y     = xv_reg;
                    ret_next = ST_FIN_ADD;
                end else if (k_reg[0]) begin
                    mm_x     = ba_reg;
                    mm_y     = ra_reg;
                    ret_next = ST_JB_RA;
                end else begin
                    mm_cmd.start = 1'b0;
                end
                state_next = (k_reg != '0 && !k_reg[0]) ? ST_JSQ : ST_WAIT;
            end

            ST_JB_RA: begin
                // Fold base into accumulated map: ra = ba*ra, rb = ba*rb + bb
                ra_next      = mm_result;
                mm_cmd.start = 1'b1;
                mm_cmd.op    = OP_MUL;
                mm_x         = ba_reg;
                mm_y         = rb_reg;
                ret_next     = ST_JB_RB;
                state_next   = ST_WAIT;
            end

            ST_JB_RB: begin
                rb_next    = add_mod(mm_result, bb_reg, m_eff);
                state_next = ST_JSQ;
            end

            ST_JSQ: begin
                mm_cmd.start = 1'b1;
                mm_cmd.op    = OP_MUL;
                state_next   = ST_WAIT;
                if (k_reg[POSITION_WIDTH-1:1] == '0) begin
                    // Last bit done: skip the unused squaring and apply map to x
                    k_next   = '0;
                    mm_x     = ra_reg;
                    mm_y     = xv_reg;
                    ret_next = ST_FIN_ADD;
                end else begin
                    // Square the base map, increment first while ba is still old
                    mm_x     = ba_reg;
                    mm_y     = bb_reg;
                    ret_next = ST_SQ_B;
                end
            end

            ST_SQ_B: begin
                bb_next      = add_mod(mm_result, bb_reg, m_eff);
                mm_cmd.start = 1'b1;
                mm_cmd.op    = OP_MUL;
                mm_x         = ba_reg;
                mm_y         = ba_reg;
                ret_next     = ST_SQ_A;
                state_next   = ST_WAIT;
            end

            ST_SQ_A: begin
                ba_next    = mm_result;
                k_next     = k_reg >> 1;
                state_next = ST_JBIT;
            end

            ST_FIN_ADD: begin
                cur_val_next = add_mod(mm_result, rb_reg, m_eff);
                cur_pos_next = (req_reg.req_type == REQ_SEEK) ? req_reg.target_position
                                                              : cur_pos_reg + POSITION_WIDTH'(1);
                started_next = 1'b1;
                state_next   = ST_DELIVER;
            end

            ST_DELIVER: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                = 1'b1;
                    m_data_next.rand_value      = cur_val_reg;
                    m_data_next.value_position  = cur_pos_reg;
                    state_next                  = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            red_idx_reg <= RED_A;
            cur_val_reg <= '0;
            cur_pos_reg <= '0;
            started_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            red_idx_reg <= red_idx_next;
            cur_val_reg <= cur_val_next;
            cur_pos_reg <= cur_pos_next;
            started_reg <= started_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg    <= req_next;
        k_reg      <= k_next;
        ba_reg     <= ba_next;
        bb_reg     <= bb_next;
        ra_reg     <= ra_next;
        rb_reg     <= rb_next;
        xv_reg     <= xv_next;
        m_data_reg <= m_data_next;
    end

endmodule
